// ----- src/dof_pkg.sv -----
// ---------------------------------------------------------------------------
// dof_pkg: shared types and constants for the depth-of-field limits block
// Fixed-point constants, the 2^(k/16) table and the sideband word layouts
// carried along the divider cell chains.
// ---------------------------------------------------------------------------
package dof_pkg;

   // display cap in mm (9999 m)
   localparam logic [23:0] LIMIT_CAP = 24'd9999000;
   // hyperfocal saturation value, Q16 mm
   localparam logic [47:0] H_MAX     = 48'hFFFF_FFFF_FFFF;
   localparam logic [7:0]  COC_RESET = 8'd19;
   localparam logic [9:0]  MM_PER_M  = 10'd1000;
   localparam logic [7:0]  AV_OFFSET = 8'd8;

   // round(2^(k/16) * 65536), except k = 9 and 11, whose entries are lower
   function automatic logic [16:0] pow_tab(input logic [3:0] k);
      logic [16:0] v;
      case (k)
         4'd0:    v = 17'd65536;
         4'd1:    v = 17'd68438;
         4'd2:    v = 17'd71468;
         4'd3:    v = 17'd74632;
         4'd4:    v = 17'd77936;
         4'd5:    v = 17'd81386;
         4'd6:    v = 17'd84990;
         4'd7:    v = 17'd88752;
         4'd8:    v = 17'd92682;
         4'd9:    v = 17'd96715;
         4'd10:   v = 17'd101070;
         4'd11:   v = 17'd105468;
         4'd12:   v = 17'd110218;
         4'd13:   v = 17'd115098;
         4'd14:   v = 17'd120194;
         default: v = 17'd125515;
      endcase
      return v;
   endfunction

   // sideband through the hyperfocal divider chain
   typedef struct packed {
      logic [10:0] focal;
      logic [23:0] fd_mm;
      logic        h_sat;
   } hyp_side_type;

   // sideband through the near-limit divider chain
   typedef struct packed {
      logic [47:0] far_rem;
      logic [23:0] far_dq;
      logic [47:0] far_den;
      logic        near_sat;
      logic        far_sat;
      logic        invalid;
      logic        infinite;
   } near_side_type;

   // sideband through the far-limit divider chain
   typedef struct packed {
      logic [23:0] near_mm;
      logic        far_sat;
      logic        infinite;
      logic        invalid;
   } far_side_type;

endpackage

// ----- src/dof_div_cell.sv -----
// ---------------------------------------------------------------------------
// dof_div_cell: one restoring-division step with a pipeline register
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits and shifts the quotient bit in. Divisor and sideband ride
// along. Holds its word while the next cell is stalled.
// ---------------------------------------------------------------------------
module dof_div_cell #(
   parameter int RW = 32,
   parameter int NW = 48,
   parameter int SW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [RW-1:0] in_rem,
   input  logic [NW-1:0] in_dq,
   input  logic [RW-1:0] in_dvs,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [RW-1:0] out_rem,
   output logic [NW-1:0] out_dq,
   output logic [RW-1:0] out_dvs,
   output logic [SW-1:0] out_side
);

   logic          valid_ff;
   logic [RW-1:0] rem_ff, rem_in;
   logic [NW-1:0] dq_ff, dq_in;
   logic [RW-1:0] dvs_ff;
   logic [SW-1:0] side_ff;
   logic [RW:0]   trial;
   logic          fits;

   // trial subtract
   always_comb begin
      trial  = {in_rem, in_dq[NW-1]};
      fits   = trial >= {1'b0, in_dvs};
      rem_in = fits ? RW'(trial - {1'b0, in_dvs}) : trial[RW-1:0];
      dq_in  = {in_dq[NW-2:0], fits};
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rem_ff  <= rem_in;
         dq_ff   <= dq_in;
         dvs_ff  <= in_dvs;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_dq    = dq_ff;
   assign out_dvs   = dvs_ff;
   assign out_side  = side_ff;

endmodule

// ----- src/depth_of_field_limits.sv -----
// ---------------------------------------------------------------------------
// depth_of_field_limits: near and far sharp limits of a lens setting
// Computes hyperfocal distance, then near and far limits in mm, through
// rows of restoring-division cells.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one word per lens setting (focal length, focus distance,
//            aperture in 1/8 EV). Accepted when req_tvalid && req_tready.
//   rsp_*  : one word per setting: near and far limits in tdata, the
//            infinite-far and invalid flags in tuser.
//   csr_*  : circle of confusion in um; always ready. Write only while idle.
// Throughput: one word per cycle while rsp_tready is not held low. Pipeline:
//   48 hyperfocal divider cells, 24 near and 24 far divider cells, and six
//   multiply/compare stages plus the output register.
// Every stage holds its own valid bit and the ready chain collapses bubbles,
//   so while a result waits on rsp_tready the upstream cells keep filling;
//   input stalls only once the whole row is full.
// Reset empties the pipeline and sets the circle of confusion to 19 um.
// ---------------------------------------------------------------------------
module depth_of_field_limits (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // focal_length_mm, focus_distance_m, aperture_eighth_ev
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // near_limit_mm, far_limit_mm
   output logic [1:0]  rsp_tuser,   // far_is_infinite, result_invalid
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // circle_of_confusion_um
);

   localparam int HSW = $bits(dof_pkg::hyp_side_type);
   localparam int NSW = $bits(dof_pkg::near_side_type);
   localparam int FSW = $bits(dof_pkg::far_side_type);
   localparam int HN  = 48;
   localparam int LN  = 24;

   // config register
   logic [7:0] coc_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         coc_ff <= dof_pkg::COC_RESET;
      end else if (csr_valid) begin
         coc_ff <= csr_data;
      end
   end

   // stage 1: f-number from table, f*f, focus distance in mm
   logic        s1_v_ff, s1_rdy;
   logic [10:0] s1_f_ff;
   logic [21:0] s1_ff_ff;
   logic [23:0] s1_fdmm_ff, s1_nq_ff;
   logic [7:0]  t_exp;
   logic [24:0] nq_full;
   logic [10:0] req_f;
   logic [13:0] req_fdm;
   logic [6:0]  req_av;

   assign req_f   = req_tdata[10:0];
   assign req_fdm = req_tdata[24:11];
   assign req_av  = req_tdata[31:25];

   always_comb begin
      t_exp   = {1'b0, req_av} + dof_pkg::AV_OFFSET;
      nq_full = {8'b0, dof_pkg::pow_tab(t_exp[3:0])} << t_exp[7:4];
   end

   logic s2_rdy;
   assign s1_rdy     = !s1_v_ff || s2_rdy;
   assign req_tready = s1_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_rdy) begin
         s1_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy && req_tvalid) begin
         s1_f_ff    <= req_f;
         s1_ff_ff   <= req_f * req_f;
         s1_fdmm_ff <= req_fdm * dof_pkg::MM_PER_M;
         s1_nq_ff   <= nq_full[24:1];
      end
   end

   // stage 2: numerator f*f*1000, divisor N*c
   logic        s2_v_ff;
   logic [10:0] s2_f_ff;
   logic [23:0] s2_fdmm_ff;
   logic [31:0] s2_num_ff, s2_div_ff;
   logic        s2_coc_zero;

   logic            a_v   [0:HN];
   logic            a_r   [0:HN];
   logic [31:0]     a_rem [0:HN];
   logic [HN-1:0]   a_dq  [0:HN];
   logic [31:0]     a_dvs [0:HN];
   logic [HSW-1:0]  a_side[0:HN];
   dof_pkg::hyp_side_type a_side0;

   assign s2_rdy = !s2_v_ff || a_r[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_rdy) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_rdy && s1_v_ff) begin
         s2_f_ff    <= s1_f_ff;
         s2_fdmm_ff <= s1_fdmm_ff;
         s2_num_ff  <= s1_ff_ff * dof_pkg::MM_PER_M;
         s2_div_ff  <= s1_nq_ff * coc_ff;
      end
   end

   // quotient of (num << 32) / div saturates when num[31:16] >= div
   assign s2_coc_zero = coc_ff == 8'd0;
   always_comb begin
      a_side0.focal = s2_f_ff;
      a_side0.fd_mm = s2_fdmm_ff;
      a_side0.h_sat = s2_coc_zero || ({16'b0, s2_num_ff[31:16]} >= s2_div_ff);
   end

   assign a_v[0]    = s2_v_ff;
   assign a_rem[0]  = {16'b0, s2_num_ff[31:16]};
   assign a_dq[0]   = {s2_num_ff[15:0], 32'b0};
   assign a_dvs[0]  = s2_div_ff;
   assign a_side[0] = a_side0;

   // hyperfocal divider row
   for (genvar i = 0; i < HN; i++) begin : g_hyp
      dof_div_cell #(.RW(32), .NW(HN), .SW(HSW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (a_v[i]),
         .in_ready (a_r[i]),
         .in_rem   (a_rem[i]),
         .in_dq    (a_dq[i]),
         .in_dvs   (a_dvs[i]),
         .in_side  (a_side[i]),
         .out_valid(a_v[i+1]),
         .out_ready(a_r[i+1]),
         .out_rem  (a_rem[i+1]),
         .out_dq   (a_dq[i+1]),
         .out_dvs  (a_dvs[i+1]),
         .out_side (a_side[i+1])
      );
   end

   // stage 3: H = f + f*f/(N*c), saturated
   logic        s3_v_ff, s3_rdy;
   logic [47:0] s3_h_ff, h_in;
   logic [10:0] s3_f_ff;
   logic [23:0] s3_fdmm_ff;
   logic [48:0] h_sum;
   dof_pkg::hyp_side_type a_last;

   assign a_last = dof_pkg::hyp_side_type'(a_side[HN]);

   always_comb begin
      h_sum = {1'b0, a_dq[HN]} + {22'b0, a_last.focal, 16'b0};
      h_in  = (a_last.h_sat || h_sum[48]) ? dof_pkg::H_MAX : h_sum[47:0];
   end

   logic s4_rdy;
   assign s3_rdy  = !s3_v_ff || s4_rdy;
   assign a_r[HN] = s3_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (s3_rdy) begin
         s3_v_ff <= a_v[HN];
      end
   end

   always_ff @(posedge clock) begin
      if (s3_rdy && a_v[HN]) begin
         s3_h_ff    <= h_in;
         s3_f_ff    <= a_last.focal;
         s3_fdmm_ff <= a_last.fd_mm;
      end
   end

   // stage 4: numerator term and both denominators, with their flags
   logic        s4_v_ff;
   logic [47:0] s4_a_ff, s4_bf_ff;
   logic [48:0] s4_bn_ff;
   logic        s4_inv_ff, s4_inf_ff;
   logic [23:0] s4_fdmm_ff;
   logic [47:0] fq;
   logic [39:0] fdq;
   logic [48:0] sum_n, two_fq;

   always_comb begin
      fq     = {21'b0, s3_f_ff, 16'b0};
      fdq    = {s3_fdmm_ff, 16'b0};
      sum_n  = {1'b0, s3_h_ff} + {9'b0, fdq};
      two_fq = {21'b0, s3_f_ff, 17'b0};
   end

   logic s5_rdy;
   assign s4_rdy = !s4_v_ff || s5_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (s4_rdy) begin
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_rdy && s3_v_ff) begin
         s4_a_ff    <= s3_h_ff - fq;
         s4_bn_ff   <= sum_n - two_fq;
         s4_inv_ff  <= sum_n <= two_fq;
         s4_bf_ff   <= s3_h_ff - {8'b0, fdq};
         s4_inf_ff  <= s3_h_ff <= {8'b0, fdq};
         s4_fdmm_ff <= s3_fdmm_ff;
      end
   end

   // stage 5: fd * (H - f) as two 24x24 partial products
   logic        s5_v_ff;
   logic [47:0] s5_pl_ff, s5_ph_ff, s5_bf_ff;
   logic [48:0] s5_bn_ff;
   logic        s5_inv_ff, s5_inf_ff;

   logic s6_rdy;
   assign s5_rdy = !s5_v_ff || s6_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else if (s5_rdy) begin
         s5_v_ff <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_rdy && s4_v_ff) begin
         s5_pl_ff  <= s4_fdmm_ff * s4_a_ff[23:0];
         s5_ph_ff  <= s4_fdmm_ff * s4_a_ff[47:24];
         s5_bn_ff  <= s4_bn_ff;
         s5_bf_ff  <= s4_bf_ff;
         s5_inv_ff <= s4_inv_ff;
         s5_inf_ff <= s4_inf_ff;
      end
   end

   // stage 6: full product and quotient overflow checks
   logic        s6_v_ff;
   logic [47:0] s6_phi_ff, s6_bf_ff;
   logic [23:0] s6_plo_ff;
   logic [48:0] s6_bn_ff;
   logic        s6_nsat_ff, s6_fsat_ff, s6_inv_ff, s6_inf_ff;
   logic [71:0] prod;

   assign prod = {s5_ph_ff, 24'b0} + {24'b0, s5_pl_ff};

   logic            n_v   [0:LN];
   logic            n_r   [0:LN];
   logic [48:0]     n_rem [0:LN];
   logic [LN-1:0]   n_dq  [0:LN];
   logic [48:0]     n_dvs [0:LN];
   logic [NSW-1:0]  n_side[0:LN];
   dof_pkg::near_side_type n_side0, n_last;

   assign s6_rdy = !s6_v_ff || n_r[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff <= 1'b0;
      end else if (s6_rdy) begin
         s6_v_ff <= s5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s6_rdy && s5_v_ff) begin
         s6_phi_ff  <= prod[71:24];
         s6_plo_ff  <= prod[23:0];
         s6_bn_ff   <= s5_bn_ff;
         s6_bf_ff   <= s5_bf_ff;
         s6_nsat_ff <= {1'b0, prod[71:24]} >= s5_bn_ff;
         s6_fsat_ff <= prod[71:24] >= s5_bf_ff;
         s6_inv_ff  <= s5_inv_ff;
         s6_inf_ff  <= s5_inf_ff;
      end
   end

   always_comb begin
      n_side0.far_rem  = s6_phi_ff;
      n_side0.far_dq   = s6_plo_ff;
      n_side0.far_den  = s6_bf_ff;
      n_side0.near_sat = s6_nsat_ff;
      n_side0.far_sat  = s6_fsat_ff;
      n_side0.invalid  = s6_inv_ff;
      n_side0.infinite = s6_inf_ff;
   end

   assign n_v[0]    = s6_v_ff;
   assign n_rem[0]  = {1'b0, s6_phi_ff};
   assign n_dq[0]   = s6_plo_ff;
   assign n_dvs[0]  = s6_bn_ff;
   assign n_side[0] = n_side0;

   // near-limit divider row
   for (genvar i = 0; i < LN; i++) begin : g_near
      dof_div_cell #(.RW(49), .NW(LN), .SW(NSW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (n_v[i]),
         .in_ready (n_r[i]),
         .in_rem   (n_rem[i]),
         .in_dq    (n_dq[i]),
         .in_dvs   (n_dvs[i]),
         .in_side  (n_side[i]),
         .out_valid(n_v[i+1]),
         .out_ready(n_r[i+1]),
         .out_rem  (n_rem[i+1]),
         .out_dq   (n_dq[i+1]),
         .out_dvs  (n_dvs[i+1]),
         .out_side (n_side[i+1])
      );
   end

   // near result, then far row
   logic            f_v   [0:LN];
   logic            f_r   [0:LN];
   logic [47:0]     f_rem [0:LN];
   logic [LN-1:0]   f_dq  [0:LN];
   logic [47:0]     f_dvs [0:LN];
   logic [FSW-1:0]  f_side[0:LN];
   dof_pkg::far_side_type f_side0, f_last;

   assign n_last = dof_pkg::near_side_type'(n_side[LN]);

   always_comb begin
      if (n_last.invalid) begin
         f_side0.near_mm = 24'd0;
      end else if (n_last.near_sat || n_dq[LN] > dof_pkg::LIMIT_CAP) begin
         f_side0.near_mm = dof_pkg::LIMIT_CAP;
      end else begin
         f_side0.near_mm = n_dq[LN];
      end
      f_side0.far_sat  = n_last.far_sat;
      f_side0.infinite = n_last.infinite;
      f_side0.invalid  = n_last.invalid;
   end

   assign f_v[0]    = n_v[LN];
   assign n_r[LN]   = f_r[0];
   assign f_rem[0]  = n_last.far_rem;
   assign f_dq[0]   = n_last.far_dq;
   assign f_dvs[0]  = n_last.far_den;
   assign f_side[0] = f_side0;

   for (genvar i = 0; i < LN; i++) begin : g_far
      dof_div_cell #(.RW(48), .NW(LN), .SW(FSW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (f_v[i]),
         .in_ready (f_r[i]),
         .in_rem   (f_rem[i]),
         .in_dq    (f_dq[i]),
         .in_dvs   (f_dvs[i]),
         .in_side  (f_side[i]),
         .out_valid(f_v[i+1]),
         .out_ready(f_r[i+1]),
         .out_rem  (f_rem[i+1]),
         .out_dq   (f_dq[i+1]),
         .out_dvs  (f_dvs[i+1]),
         .out_side (f_side[i+1])
      );
   end

   // output register
   logic        out_v_ff, out_rdy;
   logic [23:0] out_near_ff, out_far_ff, far_mm;
   logic        out_inf_ff, out_inv_ff;

   assign f_last = dof_pkg::far_side_type'(f_side[LN]);

   always_comb begin
      if (f_last.infinite) begin
         far_mm = 24'd0;
      end else if (f_last.far_sat || f_dq[LN] > dof_pkg::LIMIT_CAP) begin
         far_mm = dof_pkg::LIMIT_CAP;
      end else begin
         far_mm = f_dq[LN];
      end
   end

   assign out_rdy  = !out_v_ff || rsp_tready;
   assign f_r[LN]  = out_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_rdy) begin
         out_v_ff <= f_v[LN];
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy && f_v[LN]) begin
         out_near_ff <= f_last.near_mm;
         out_far_ff  <= far_mm;
         out_inf_ff  <= f_last.infinite;
         out_inv_ff  <= f_last.invalid;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {out_far_ff, out_near_ff};
   assign rsp_tuser  = {out_inv_ff, out_inf_ff};

   // checks
   a_inf_far_zero : assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_inf_ff |-> out_far_ff == 24'd0)
      else $error("far limit nonzero while flagged infinite");

   a_inv_near_zero : assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_inv_ff |-> out_near_ff == 24'd0)
      else $error("near limit nonzero while flagged invalid");

   a_cap : assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> out_near_ff <= dof_pkg::LIMIT_CAP && out_far_ff <= dof_pkg::LIMIT_CAP)
      else $error("limit above display cap");

   a_hold_out : assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !rsp_tready |=> out_v_ff && $stable(out_near_ff) && $stable(out_far_ff))
      else $error("stalled result changed");

endmodule

// ----- tb/depth_of_field_limits_test.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// depth_of_field_limits_test: self-checking bench for the depth-of-field block
// Drives lens settings over the request stream, predicts near/far limits and
// flags with a fixed-point model of its own, and checks every response word
// in order. A directed table comes first, then random phases under several
// circle-of-confusion settings, with random stalls on both streams.
// ---------------------------------------------------------------------------
module depth_of_field_limits_test;

   typedef struct {
      logic [23:0] near_mm;
      logic [23:0] far_mm;
      logic        infinite;
      logic        invalid;
   } limits_type;

   typedef struct {
      logic [7:0]  coc;
      logic [10:0] focal;
      logic [13:0] dist_m;
      logic [6:0]  av;
      bit          typed;
      limits_type  want;
   } lens_row_type;

   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 120;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = '0;

   limits_type  pending_limits[$];
   logic [7:0]  coc_shadow = dof_pkg::COC_RESET;
   int          fail_count = 0;
   int          quiet_cycles = 0;
   bit          no_idle = 1'b0;
   int          ready_hold = 0;

   // own copy of round(2^(k/16) * 65536), except k = 9 and 11, whose entries are lower
   const logic [16:0] root_tab[16] = '{
      17'd65536, 17'd68438, 17'd71468, 17'd74632, 17'd77936, 17'd81386,
      17'd84990, 17'd88752, 17'd92682, 17'd96715, 17'd101070, 17'd105468,
      17'd110218, 17'd115098, 17'd120194, 17'd125515};

   depth_of_field_limits dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // floor(m * a / b), exact, capped at the display limit
   function automatic logic [63:0] capped_ratio(logic [63:0] m, logic [63:0] a,
                                                logic [63:0] b);
      logic [63:0] qa, ra, rem, q, total;
      rem = 0;
      q = 0;
      if (m == 0 || b == 0) return 0;
      qa = a / b;
      ra = a % b;
      if (qa > dof_pkg::LIMIT_CAP) return dof_pkg::LIMIT_CAP;
      for (int i = 23; i >= 0; i--) begin
         rem = rem << 1;
         q = q << 1;
         if (m[i]) rem += ra;
         while (rem >= b) begin
            rem -= b;
            q++;
         end
      end
      total = m * qa + q;
      return (total > dof_pkg::LIMIT_CAP) ? dof_pkg::LIMIT_CAP : total;
   endfunction

   // hyperfocal distance, then near and far limits
   function automatic limits_type dof_limits(logic [10:0] focal, logic [13:0] dist_m,
                                             logic [6:0] av, logic [7:0] coc);
      limits_type  r;
      logic [63:0] fd_mm, fq, fdq, h, t, nq, num, term;
      fd_mm = 64'(dist_m) * 1000;
      fq = 64'(focal) << 16;
      fdq = fd_mm << 16;
      r = '{default: '0};
      if (coc == 0) begin
         h = dof_pkg::H_MAX;
      end else begin
         t = 64'(av) + 8;
         nq = (64'(root_tab[t[3:0]]) << (t >> 4)) >> 1;
         num = (64'(focal) * 64'(focal) * 1000) << 32;
         term = num / (nq * 64'(coc));
         h = (term > dof_pkg::H_MAX) ? dof_pkg::H_MAX : term;
         h += fq;
         if (h > dof_pkg::H_MAX) h = dof_pkg::H_MAX;
      end
      if (h + fdq <= 2 * fq) r.invalid = 1'b1;
      else r.near_mm = 24'(capped_ratio(fd_mm, h - fq, h + fdq - 2 * fq));
      if (h <= fdq) r.infinite = 1'b1;
      else r.far_mm = 24'(capped_ratio(fd_mm, h - fq, h - fdq));
      return r;
   endfunction

   function automatic void check_field(string name, logic [23:0] want,
                                       logic [23:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // response checker and stall watchdog
   always @(posedge clock) begin
      limits_type w;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_limits.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %h/%b", $time,
                        rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               w = pending_limits.pop_front();
               check_field("near_limit_mm", w.near_mm, rsp_tdata[23:0]);
               check_field("far_limit_mm", w.far_mm, rsp_tdata[47:24]);
               check_field("far_is_infinite", 24'(w.infinite), 24'(rsp_tuser[0]));
               check_field("result_invalid", 24'(w.invalid), 24'(rsp_tuser[1]));
            end
         end
      end
   end

   // response back-pressure in short bursts
   always @(posedge clock) begin
      if (no_idle || reset) begin
         rsp_tready <= !reset;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         ready_hold <= $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // write the circle of confusion once the pipeline has drained
   task automatic write_coc(logic [7:0] value);
      while (pending_limits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      forever begin
         @(negedge clock);
         if (csr_ready) break;
      end
      @(posedge clock);
      csr_valid <= 1'b0;
      coc_shadow = value;
   endtask

   // send one lens-setting word, then maybe idle
   task automatic send_lens(logic [10:0] focal, logic [13:0] dist_m, logic [6:0] av,
                            bit typed, limits_type want);
      limits_type p;
      req_tvalid <= 1'b1;
      req_tdata <= {av, dist_m, focal};
      forever begin
         @(negedge clock);
         if (req_tready) break;
      end
      @(posedge clock);
      p = dof_limits(focal, dist_m, av, coc_shadow);
      pending_limits.push_back(typed ? want : p);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   initial begin
      lens_row_type rows[$];
      limits_type   zero_lim, inv_lim;
      logic [7:0]   phase_coc[5];
      logic [10:0]  f;
      logic [13:0]  d;
      zero_lim = '{default: '0};
      inv_lim = '{near_mm: 0, far_mm: 0, infinite: 0, invalid: 1'b1};
      // directed table: coc, focal, distance, aperture, typed, expected
      rows = '{
         '{dof_pkg::COC_RESET, 11'd1, 14'd0, 7'd0, 1'b0, zero_lim},
         '{dof_pkg::COC_RESET, 11'd2047, 14'd9999, 7'd127, 1'b0, zero_lim},
         '{dof_pkg::COC_RESET, 11'd1, 14'd9999, 7'd127, 1'b0, zero_lim},
         '{dof_pkg::COC_RESET, 11'd50, 14'd3, 7'd32, 1'b0, zero_lim},
         '{dof_pkg::COC_RESET, 11'd50, 14'd10, 7'd8, 1'b0, zero_lim},
         '{dof_pkg::COC_RESET, 11'd2047, 14'd0, 7'd0, 1'b0, zero_lim},
         '{dof_pkg::COC_RESET, 11'd35, 14'd1, 7'd40, 1'b0, zero_lim},
         '{8'd255, 11'd1, 14'd0, 7'd127, 1'b1, inv_lim},
         '{8'd255, 11'd1, 14'd1, 7'd127, 1'b0, zero_lim},
         '{8'd255, 11'd2047, 14'd9999, 7'd0, 1'b0, zero_lim},
         '{8'd255, 11'd24, 14'd2, 7'd64, 1'b0, zero_lim},
         '{8'd0, 11'd1, 14'd0, 7'd0, 1'b1, zero_lim},
         '{8'd0, 11'd2047, 14'd9999, 7'd127, 1'b0, zero_lim},
         '{8'd0, 11'd100, 14'd5, 7'd50, 1'b0, zero_lim},
         '{8'd1, 11'd1, 14'd9999, 7'd0, 1'b0, zero_lim},
         '{8'd1, 11'd2047, 14'd1, 7'd127, 1'b0, zero_lim},
         '{8'd1, 11'd200, 14'd100, 7'd15, 1'b0, zero_lim}};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].coc != coc_shadow) begin
            req_tvalid <= 1'b0;
            write_coc(rows[i].coc);
         end
         send_lens(rows[i].focal, rows[i].dist_m, rows[i].av, rows[i].typed,
                   rows[i].want);
      end

      // random phases; the last one runs without idling at the default coc
      phase_coc = '{8'($urandom_range(2, 254)), 8'd255, 8'd1,
                    8'($urandom_range(0, 255)), dof_pkg::COC_RESET};
      for (int ph = 0; ph < 5; ph++) begin
         req_tvalid <= 1'b0;
         write_coc(phase_coc[ph]);
         if (ph == 4) no_idle = 1'b1;
         repeat (107) begin
            f = ($urandom_range(0, 1) == 0) ? 11'($urandom_range(1, 300))
                                            : 11'($urandom_range(1, 2047));
            d = ($urandom_range(0, 1) == 0) ? 14'($urandom_range(0, 40))
                                            : 14'($urandom_range(0, 16383));
            send_lens(f, d, 7'($urandom_range(0, 127)), 1'b0, zero_lim);
         end
      end
      req_tvalid <= 1'b0;

      while (pending_limits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- depth_of_field_limits.f -----
src/dof_pkg.sv
src/dof_div_cell.sv
src/depth_of_field_limits.sv
tb/depth_of_field_limits_test.sv
